@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on the block clock
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define AMS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define AMS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/ams_pkg.sv @@
package ams_pkg;

   localparam int WINDOW      = 10;
   localparam int NUM_AXES    = 3;
   localparam int SAMPLE_W    = 13;
   localparam int ACCEL_W     = 16;
   localparam int OFFSET_W    = 13;

   localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW);
   localparam int MAG_W       = SUM_W;
   localparam int RECIP_W     = MAG_W + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << MAG_W) / WINDOW);

   localparam int SCALE_MUL_W = 11;
   localparam logic signed [SCALE_MUL_W-1:0] SCALE_MUL = 11'sd1000;
   localparam int SCALE_SHIFT = 8;
   localparam int PROD_W      = SAMPLE_W + 1 + SCALE_MUL_W;

   localparam int REQ_DATA_W  = ((NUM_AXES * SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_BITS    = NUM_AXES * (SAMPLE_W + ACCEL_W);
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;
   localparam int CSR_ADDR_W  = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_OFFSET_X = 2'd0,
      CSR_OFFSET_Y = 2'd1,
      CSR_OFFSET_Z = 2'd2
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [OFFSET_W-1:0] offset_type;
   typedef logic signed [ACCEL_W-1:0]  accel_type;

   // stage load strobes shared by all lanes
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic load_c;
   } lane_ctl_type;

endpackage

@@ rtl/ams_lane.sv @@
module ams_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  ams_pkg::lane_ctl_type       ctl,
   input  logic [ams_pkg::SLOT_W-1:0]  slot,
   input  ams_pkg::sample_type         sample,
   output ams_pkg::sample_type         mean
);

   localparam int T_W = ams_pkg::SUM_W + 2;
   localparam int MW  = ams_pkg::MAG_W;

   ams_pkg::sample_type ring_ff [ams_pkg::WINDOW];
   logic signed [ams_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic signed [ams_pkg::SUM_W-1:0] old_ext, new_ext;

   logic [T_W-1:0]  t_val, t_rnd;
   logic [T_W-2:0]  q1, q1_mag;
   logic            neg_in, neg_ff;
   logic [MW-1:0]   mag_in, mag_ff;
   logic [MW+ams_pkg::RECIP_W-1:0] prod;
   logic [MW-1:0]   qe_in, qe_ff;

   logic [MW-1:0]   rem, quot;
   logic [MW-1:0]   mean_mag;
   ams_pkg::sample_type mean_in, mean_ff;

   // ring update and running sum, this is stage a
   assign old_ext = ams_pkg::SUM_W'(ring_ff[slot]);
   assign new_ext = ams_pkg::SUM_W'(sample);
   assign sum_in  = sum_ff - old_ext + new_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ams_pkg::WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (ctl.load_a) begin
         ring_ff[slot] <= sample;
         sum_ff        <= sum_in;
      end
   end

   // (2*sum + n) / 2 truncated toward zero, then reciprocal estimate of / n
   always_comb begin
      t_val  = {sum_ff[ams_pkg::SUM_W-1], sum_ff, 1'b0} + T_W'(ams_pkg::WINDOW);
      neg_in = t_val[T_W-1];
      t_rnd  = t_val + T_W'(neg_in);
      q1     = t_rnd[T_W-1:1];
      q1_mag = neg_in ? (~q1 + 1'b1) : q1;
      mag_in = q1_mag[MW-1:0];
      prod   = mag_in * ams_pkg::RECIP;
      qe_in  = prod[MW +: MW];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_b) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
         qe_ff  <= qe_in;
      end
   end

   // estimate is low by at most one
   always_comb begin
      rem      = mag_ff - MW'(qe_ff * MW'(ams_pkg::WINDOW));
      quot     = (rem >= MW'(ams_pkg::WINDOW)) ? qe_ff + 1'b1 : qe_ff;
      mean_mag = neg_ff ? (~quot + 1'b1) : quot;
      mean_in  = mean_mag[ams_pkg::SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_c) begin
         mean_ff <= mean_in;
      end
   end

   assign mean = mean_ff;

endmodule

@@ rtl/ams_merge.sv @@
module ams_merge (
   input  logic                              clock,
   input  logic                              load,
   input  ams_pkg::sample_type               mean   [ams_pkg::NUM_AXES],
   input  ams_pkg::offset_type               offset [ams_pkg::NUM_AXES],
   output logic [ams_pkg::RSP_DATA_W-1:0]    data
);

   localparam int SW = ams_pkg::SAMPLE_W;
   localparam int AW = ams_pkg::ACCEL_W;
   localparam int NA = ams_pkg::NUM_AXES;

   logic signed [SW:0]                  diff  [NA];
   logic signed [ams_pkg::PROD_W-1:0]   prod  [NA];
   logic signed [ams_pkg::PROD_W-1:0]   prod_r[NA];
   ams_pkg::accel_type                  accel_in [NA];
   ams_pkg::accel_type                  accel_ff [NA];
   ams_pkg::sample_type                 mean_ff  [NA];

   // subtract offset, scale by 1000/256 truncating toward zero
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         diff[a]     = {mean[a][SW-1], mean[a]} - {offset[a][SW-1], offset[a]};
         prod[a]     = diff[a] * ams_pkg::SCALE_MUL;
         prod_r[a]   = prod[a] + $signed({{(ams_pkg::PROD_W - ams_pkg::SCALE_SHIFT){1'b0}},
                       {ams_pkg::SCALE_SHIFT{prod[a][ams_pkg::PROD_W-1]}}});
         accel_in[a] = prod_r[a][ams_pkg::SCALE_SHIFT +: AW];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int a = 0; a < NA; a++) begin
            mean_ff[a]  <= mean[a];
            accel_ff[a] <= accel_in[a];
         end
      end
   end

   always_comb begin
      data = '0;
      for (int a = 0; a < NA; a++) begin
         data[a*SW +: SW]           = mean_ff[a];
         data[NA*SW + a*AW +: AW]   = accel_ff[a];
      end
   end

endmodule

@@ rtl/accel_moving_average_scale.sv @@
// channel  dir  tdata fields (lowest bit up)                  handshake
// req      in   sample_x, sample_y, sample_z (13b each)        req_tvalid/req_tready
// rsp      out  mean_x/y/z (13b), accel_x/y/z (16b)            rsp_tvalid/rsp_tready
// csr      in   offset_x/y/z at index 0..2 (13b)               csr_we
//
// one word per cycle while rsp_tready holds; valid flows a, b, c, d into rsp_tvalid
// pipeline: ring and running sum, reciprocal multiply, divide fix-up,
// offset and scale multiply into the output register
// each stage holds independently, so gaps close up under a stalled output
// synchronous reset clears the rings, sums, write slot, offsets and valids
`include "assert_macros.svh"

module accel_moving_average_scale (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ams_pkg::REQ_DATA_W-1:0]       req_tdata,  // sample_x, sample_y, sample_z
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ams_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // mean_x/y/z, accel_x/y/z
   input  logic                                 csr_we,
   input  logic [ams_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [ams_pkg::OFFSET_W-1:0]         csr_wdata
);

   localparam int NA = ams_pkg::NUM_AXES;

   logic valid_a_ff, valid_b_ff, valid_c_ff, valid_d_ff;
   logic adv_a, adv_b, adv_c, adv_d;
   logic accept;
   ams_pkg::lane_ctl_type ctl;

   logic [ams_pkg::SLOT_W-1:0] slot_ff, slot_in;
   ams_pkg::offset_type offset_ff [NA];
   ams_pkg::sample_type mean [NA];

   // each stage loads when empty or when the next one moves
   assign adv_d  = !valid_d_ff || rsp_tready;
   assign adv_c  = !valid_c_ff || adv_d;
   assign adv_b  = !valid_b_ff || adv_c;
   assign adv_a  = !valid_a_ff || adv_b;
   assign req_tready = adv_a;
   assign accept = req_tvalid && adv_a;

   assign ctl.load_a = accept;
   assign ctl.load_b = adv_b;
   assign ctl.load_c = adv_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else begin
         if (adv_a) valid_a_ff <= req_tvalid;
         if (adv_b) valid_b_ff <= valid_a_ff;
         if (adv_c) valid_c_ff <= valid_b_ff;
         if (adv_d) valid_d_ff <= valid_c_ff;
      end
   end

   assign slot_in = (slot_ff == ams_pkg::SLOT_W'(ams_pkg::WINDOW - 1)) ?
                    '0 : slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (accept) begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NA; a++) begin
            offset_ff[a] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_addr)
            ams_pkg::CSR_OFFSET_X: offset_ff[0] <= csr_wdata;
            ams_pkg::CSR_OFFSET_Y: offset_ff[1] <= csr_wdata;
            ams_pkg::CSR_OFFSET_Z: offset_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar g = 0; g < NA; g++) begin : g_lane
      ams_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .slot   (slot_ff),
         .sample (req_tdata[g*ams_pkg::SAMPLE_W +: ams_pkg::SAMPLE_W]),
         .mean   (mean[g])
      );
   end

   ams_merge u_merge (
      .clock  (clock),
      .load   (adv_d),
      .mean   (mean),
      .offset (offset_ff),
      .data   (rsp_tdata)
   );

   assign rsp_tvalid = valid_d_ff;

   `AMS_ASSERT(a_ready_when_out_free, !rsp_tvalid |-> req_tready, "pipeline blocked with empty output")
   `AMS_ASSERT(a_slot_range, slot_ff <= ams_pkg::SLOT_W'(ams_pkg::WINDOW - 1), "write slot out of range")
   `AMS_ASSERT(a_accept_fills, req_tvalid && req_tready |=> valid_a_ff, "accepted word lost at entry")
   `AMS_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_tvalid, "output valid after reset")

endmodule
